// ----- rtl/frac_n_synth_divider_calc_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the fractional-N divider calculation block.
// They use the clock i_clk and the reset i_rst_n of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef FRAC_N_SYNTH_DIVIDER_CALC_MACROS_SVH
`define FRAC_N_SYNTH_DIVIDER_CALC_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define FNSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FNSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fnsd_pkg.sv -----
// ---------------------------------------------------------------------------
// fnsd_pkg
// Types and constants shared by the divider calculation front, queue and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fnsd_pkg;

    localparam int FREQ_W = 22;
    localparam int VCO_W  = 23;
    localparam int X1_W   = 25;
    localparam int EXP_W  = 3;
    localparam int ADDR_W = 7;
    localparam int DATA_W = 16;
    localparam int NINT_W = 7;
    localparam int REM_W  = 14;
    localparam int FRAC_W = 24;

    localparam logic [FREQ_W-1:0] F_MIN_KHZ     = 22'd85000;
    localparam logic [FREQ_W-1:0] F_MAX_KHZ     = 22'd2700000;
    localparam logic [VCO_W-1:0]  VCO_SPAN_KHZ  = 23'd5400000;
    localparam logic [VCO_W-1:0]  VCO_SPLIT_KHZ = 23'd3200000;
    localparam logic [EXP_W-1:0]  EXP_MIN       = 3'd1;
    localparam int                EXP_MAX       = 5;

    // floor(x/13) = (x * M13) >> 25 with one correction step, x < 2^25
    localparam logic [21:0] M13   = 22'd2581110;
    localparam logic [4:0]  DIV13 = 5'd13;
    // floor(d/10000) = (d * M10K) >> 20 with one correction step, d < 2^20
    localparam logic [6:0]  M10K      = 7'd104;
    localparam logic [19:0] DEC_SCALE = 20'd10000;
    // floor(x/625) = (x * M625) >> 34 with one correction step, x < 2^34
    localparam logic [24:0] M625   = 25'd27487790;
    localparam logic [9:0]  DIV625 = 10'd625;

    localparam logic [1:0] PRESC_LO = 2'd1;
    localparam logic [1:0] PRESC_HI = 2'd2;
    localparam logic [1:0] CP_BITS  = 2'b10;

    localparam logic [ADDR_W-1:0] ADDR_CFG  = 7'h08;
    localparam logic [ADDR_W-1:0] ADDR_NDIV = 7'h0F;
    localparam logic [ADDR_W-1:0] ADDR_FMSB = 7'h10;
    localparam logic [ADDR_W-1:0] ADDR_FLSB = 7'h11;

    // (0xFC06 & 0x7FFE) | 0x8000
    localparam logic [DATA_W-1:0] CFG_DATA = (16'hFC06 & 16'h7FFE) | 16'h8000;

    typedef logic [1:0] t_beat;
    localparam t_beat BEAT_CFG  = 2'd0;
    localparam t_beat BEAT_NDIV = 2'd1;
    localparam t_beat BEAT_FMSB = 2'd2;
    localparam t_beat BEAT_FLSB = 2'd3;

    typedef struct packed {
        logic [EXP_W-1:0] expo;
        logic             fbk4;
    } t_tag;

    typedef struct packed {
        logic [X1_W-1:0] x1;    // VCO frequency times 5
        t_tag            tag;
    } t_item;

endpackage

`default_nettype wire

// ----- rtl/fnsd_front.sv -----
// ---------------------------------------------------------------------------
// fnsd_front
// Clamp the request, pick the LO divider exponent and VCO band, register it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fnsd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [fnsd_pkg::FREQ_W-1:0] i_lo_freq_khz,
    output logic                            o_push,
    input  wire logic                       i_q_ready,
    output fnsd_pkg::t_item                 o_item
);
    import fnsd_pkg::*;

    logic             r_vld;
    logic             n_vld;
    t_item            r_item;
    logic             w_acc;
    logic [FREQ_W-1:0] w_f;
    logic [27:0]      w_fx;
    logic [27:0]      w_vco_w;
    logic [EXP_W-1:0] w_expo;
    logic [VCO_W-1:0] w_vco;
    t_item            w_item;

    assign o_in_stall = r_vld && !i_q_ready;
    assign o_push     = r_vld && i_q_ready;
    assign o_item     = r_item;
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_lo_freq_khz < F_MIN_KHZ) begin
            w_f = F_MIN_KHZ;
        end else if (i_lo_freq_khz > F_MAX_KHZ) begin
            w_f = F_MAX_KHZ;
        end else begin
            w_f = i_lo_freq_khz;
        end
        w_fx = {6'b0, w_f};
        // largest exponent that keeps f << e within the VCO span
        w_expo = EXP_MIN;
        for (int e = 2; e <= EXP_MAX; e++) begin
            if ((w_fx << e) <= {5'b0, VCO_SPAN_KHZ}) begin
                w_expo = EXP_W'(e);
            end
        end
        w_vco_w       = w_fx << w_expo;
        w_vco         = w_vco_w[VCO_W-1:0];
        w_item.x1     = {w_vco, 2'b00} + {2'b00, w_vco};
        w_item.tag.expo = w_expo;
        w_item.tag.fbk4 = w_vco > VCO_SPLIT_KHZ;
    end

    assign n_vld = w_acc || (r_vld && !i_q_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= w_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fnsd_queue.sv -----
// ---------------------------------------------------------------------------
// fnsd_queue
// Short FIFO between the classifying front and the arithmetic back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frac_n_synth_divider_calc_macros.svh"

module fnsd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fnsd_pkg::t_item i_item,
    output logic                 o_ready,
    input  wire logic            i_pop,
    output logic                 o_vld,
    output fnsd_pkg::t_item      o_item
);
    import fnsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `FNSD_ASSERT_NEXT(a_q_fill, i_push && !i_pop, r_cnt == $past(r_cnt) + CW'(1), "queue fill count did not rise on push")
    `FNSD_ASSERT_NEXT(a_q_drain, i_pop && !i_push, r_cnt == $past(r_cnt) - CW'(1), "queue fill count did not fall on pop")

endmodule

`default_nettype wire

// ----- rtl/fnsd_back.sv -----
// ---------------------------------------------------------------------------
// fnsd_back
// Divider arithmetic pipeline and the four-write register sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "frac_n_synth_divider_calc_macros.svh"

module fnsd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire fnsd_pkg::t_item             i_item,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fnsd_pkg::ADDR_W-1:0]      o_reg_addr,
    output logic [fnsd_pkg::DATA_W-1:0]      o_reg_data,
    output logic                             o_last_write
);
    import fnsd_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_take;
    logic [NSTG-1:0] w_in;
    t_tag            r_tag [NSTG];

    // stage 0: reciprocal estimate of x1 / 13
    logic [46:0]      w_p0;
    logic [21:0]      r0_q;
    logic [X1_W-1:0]  r0_x1;
    // stage 1: correct, then divide by the feedback divider
    logic [25:0]      w_m1;
    logic [25:0]      w_r1;
    logic [21:0]      w_q1;
    logic [19:0]      w_d1;
    logic [19:0]      r1_d;
    // stage 2: reciprocal estimate of d / 10000
    logic [26:0]      w_p2;
    logic [NINT_W-1:0] r2_nq;
    logic [19:0]      r2_d;
    // stage 3: integer N and the decimal remainder
    logic [19:0]      w_m3;
    logic [19:0]      w_r3;
    logic             w_hi3;
    logic [19:0]      w_rem3;
    logic [NINT_W-1:0] r3_nint;
    logic [REM_W-1:0] r3_rem;
    // stage 4: reciprocal estimate of (rem << 20) / 625
    logic [38:0]      w_p4;
    logic [24:0]      r4_fq;
    logic [REM_W-1:0] r4_rem;
    logic [NINT_W-1:0] r4_nint;
    // correction into the sequencer
    logic [34:0]      w_x5;
    logic [34:0]      w_m5;
    logic [34:0]      w_r5;
    logic [24:0]      w_fq5;

    // register write sequencer
    logic              r_ser_vld;
    logic              n_ser_vld;
    t_beat             r_beat;
    t_beat             n_beat;
    logic [NINT_W-1:0] r_nint;
    t_tag              r_ser_tag;
    logic [FRAC_W-1:0] r_frac;
    logic              w_out_acc;
    logic              w_last;
    logic              w_ser_take;
    logic              w_load;
    logic [1:0]        w_presc;

    // ---- pipeline flow control ----
    assign w_out_acc  = r_ser_vld && !i_out_stall;
    assign w_last     = r_beat == BEAT_FLSB;
    assign w_ser_take = !r_ser_vld || (w_out_acc && w_last);
    assign w_load     = r_vld[NSTG-1] && w_ser_take;

    always_comb begin
        w_take[NSTG] = w_ser_take;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
        w_in[0] = i_vld && w_take[0];
        for (int k = 1; k < NSTG; k++) begin
            w_in[k] = r_vld[k-1] && w_take[k];
        end
        for (int k = 0; k < NSTG; k++) begin
            n_vld[k] = w_in[k] || (r_vld[k] && !w_take[k+1]);
        end
    end

    assign o_pop = w_in[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ---- arithmetic ----
    always_comb begin
        w_p0 = {22'b0, i_item.x1} * {25'b0, M13};

        w_m1 = {4'b0, r0_q} * {21'b0, DIV13};
        w_r1 = {1'b0, r0_x1} - w_m1;
        w_q1 = r0_q + 22'(w_r1 >= {21'b0, DIV13});
        w_d1 = r_tag[0].fbk4 ? w_q1[21:2] : w_q1[20:1];

        w_p2 = {7'b0, r1_d} * {20'b0, M10K};

        w_m3   = {13'b0, r2_nq} * DEC_SCALE;
        w_r3   = r2_d - w_m3;
        w_hi3  = w_r3 >= DEC_SCALE;
        w_rem3 = w_hi3 ? (w_r3 - DEC_SCALE) : w_r3;

        w_p4 = {25'b0, r3_rem} * {14'b0, M625};

        w_x5  = {1'b0, r4_rem, 20'b0};
        w_m5  = {10'b0, r4_fq} * {25'b0, DIV625};
        w_r5  = w_x5 - w_m5;
        w_fq5 = r4_fq + 25'(w_r5 >= {25'b0, DIV625});
    end

    always_ff @(posedge i_clk) begin
        if (w_in[0]) begin
            r0_q     <= w_p0[46:25];
            r0_x1    <= i_item.x1;
            r_tag[0] <= i_item.tag;
        end
        if (w_in[1]) begin
            r1_d     <= w_d1;
            r_tag[1] <= r_tag[0];
        end
        if (w_in[2]) begin
            r2_nq    <= w_p2[26:20];
            r2_d     <= r1_d;
            r_tag[2] <= r_tag[1];
        end
        if (w_in[3]) begin
            r3_nint  <= r2_nq + NINT_W'(w_hi3);
            r3_rem   <= w_rem3[REM_W-1:0];
            r_tag[3] <= r_tag[2];
        end
        if (w_in[4]) begin
            r4_fq    <= w_p4[38:14];
            r4_rem   <= r3_rem;
            r4_nint  <= r3_nint;
            r_tag[4] <= r_tag[3];
        end
    end

    // ---- write sequencer ----
    always_comb begin
        n_ser_vld = w_load || (r_ser_vld && !(w_out_acc && w_last));
        n_beat    = r_beat;
        if (w_load) begin
            n_beat = BEAT_CFG;
        end else if (w_out_acc) begin
            n_beat = r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_beat    <= BEAT_CFG;
        end else begin
            r_ser_vld <= n_ser_vld;
            r_beat    <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_nint    <= r4_nint;
            r_ser_tag <= r_tag[NSTG-1];
            r_frac    <= w_fq5[FRAC_W-1:0];
        end
    end

    assign w_presc = r_ser_tag.fbk4 ? PRESC_HI : PRESC_LO;

    always_comb begin
        case (r_beat)
            BEAT_CFG: begin
                o_reg_addr = ADDR_CFG;
                o_reg_data = CFG_DATA;
            end
            BEAT_NDIV: begin
                o_reg_addr = ADDR_NDIV;
                o_reg_data = {2'b00, r_nint, r_ser_tag.expo, w_presc, CP_BITS};
            end
            BEAT_FMSB: begin
                o_reg_addr = ADDR_FMSB;
                o_reg_data = r_frac[FRAC_W-1:8];
            end
            BEAT_FLSB: begin
                o_reg_addr = ADDR_FLSB;
                o_reg_data = {r_frac[7:0], 8'h00};
            end
            default: begin
                o_reg_addr = ADDR_CFG;
                o_reg_data = CFG_DATA;
            end
        endcase
    end

    assign o_out_valid  = r_ser_vld;
    assign o_last_write = w_last;

    `FNSD_ASSERT_NEXT(a_beat_step, w_out_acc && !w_last, r_ser_vld && (r_beat == $past(r_beat) + 2'd1), "write sequence skipped or lost a beat")
    `FNSD_ASSERT_SAME(a_rem_range, r_vld[3], r3_rem < DEC_SCALE[REM_W-1:0], "decimal remainder out of range after correction")
    `FNSD_ASSERT_NEXT(a_tail_hold, r_vld[NSTG-1] && !w_ser_take, r_vld[NSTG-1] && $stable(r4_fq), "last pipeline stage lost its request while blocked")

endmodule

`default_nettype wire

// ----- rtl/frac_n_synth_divider_calc.sv -----
// Fractional-N divider calculation: each request carries an LO frequency in kHz
// (clamped to 85000..2700000) and answers with four 16-bit synthesizer register
// writes in order: 0x08 (fixed 0xFC06), 0x0F (integer N, LO exponent, prescaler,
// fixed low bits), 0x10 (fraction MSB) and 0x11 (fraction LSB in the high byte),
// with o_last_write set on the fourth. The result port carries one write per
// cycle while i_out_stall is low, and each request takes four writes. With an
// empty pipeline a request passes through the front register, a queue slot,
// five arithmetic stages and the write sequencer before its first write shows.
// A new request is taken while earlier ones are still in the arithmetic stages
// or being written out.
// ---------------------------------------------------------------------------
// frac_n_synth_divider_calc
// Top level: front classifier, request queue and arithmetic/write back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frac_n_synth_divider_calc #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [fnsd_pkg::FREQ_W-1:0]  i_lo_freq_khz,
    // register write channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [fnsd_pkg::ADDR_W-1:0]       o_reg_addr,
    output logic [fnsd_pkg::DATA_W-1:0]       o_reg_data,
    output logic                              o_last_write
);
    import fnsd_pkg::*;

    // front to queue
    logic  w_push;
    logic  w_q_ready;
    t_item w_front_item;
    // queue to back
    logic  w_q_vld;
    logic  w_pop;
    t_item w_q_item;

    // Clamp the request, find the exponent and VCO band, hold it for the queue.
    fnsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_lo_freq_khz (i_lo_freq_khz),
        .o_push        (w_push),
        .i_q_ready     (w_q_ready),
        .o_item        (w_front_item)
    );

    // Decouple the front from the back so either side can stall alone.
    fnsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item)
    );

    // Work out N and the fraction, then emit the four register writes.
    fnsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_q_vld),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reg_addr   (o_reg_addr),
        .o_reg_data   (o_reg_data),
        .o_last_write (o_last_write)
    );

endmodule

`default_nettype wire
